// ----- src/fixed_slot_pool_allocator_unit_assert.svh -----
// Assertion macros for the fixed slot pool allocator.
// Used by the top level; no other dependencies.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FSPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FSPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSPA_ASSERT(label, prop, msg)
`define FSPA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/fspa_pkg.sv -----
// Shared types and constants of the fixed slot pool allocator.
// No dependencies; imported by fspa_ctrl, fspa_datapath and the top level.
`default_nettype none

package fspa_pkg;

    localparam int POOL_DEPTH_DEF = 1024;

    localparam int IDX_W    = 10;
    localparam int OFS_W    = 22;
    localparam int CNT_W    = 11;
    localparam int SIZE_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [SIZE_W-1:0] SIZE_CAP = 13'd4096;

    // operation codes; code three acts as a get
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RETURN  = 2'd1;
    localparam logic [1:0] OP_GET     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [OFS_W-1:0] byte_offset;
        status_t          status;
        logic [CNT_W-1:0] free_entries;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic decide;
        logic fetch;
        logic mult;
        logic emit;
    } fspa_cmd_t;

    typedef struct packed {
        logic pop_sel;
        logic out_free;
    } fspa_sts_t;

endpackage

`default_nettype wire

// ----- src/fspa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fspa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/fspa_ctrl.sv -----
// Sequencer of the fixed slot pool allocator: one transaction at a time.
// Depends on fspa_pkg.
`default_nettype none

module fspa_ctrl
    import fspa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output fspa_cmd_t      cmd,
    input  wire fspa_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FETCH,
        S_MULT,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_comb begin
        cmd        = '0;
        cmd.latch  = (state_reg == S_IDLE) && ready_reg && s_valid;
        cmd.decide = (state_reg == S_DECIDE);
        cmd.fetch  = (state_reg == S_FETCH);
        cmd.mult   = (state_reg == S_MULT);
        cmd.emit   = (state_reg == S_EMIT) && sts.out_free;
    end

    assign s_ready = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (ready_reg && s_valid) begin
                        ready_reg <= 1'b0;
                        state_reg <= S_DECIDE;
                    end else begin
                        ready_reg <= 1'b1;
                    end
                end
                S_DECIDE: begin
                    state_reg <= sts.pop_sel ? S_FETCH : S_MULT;
                end
                S_FETCH: begin
                    state_reg <= S_MULT;
                end
                S_MULT: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (sts.out_free) begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    ready_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/fspa_datapath.sv -----
// Datapath: config registers, stack pointer, high-water counter, free stack,
// offset multiplier and output register. Depends on fspa_pkg, fspa_ram.
`default_nettype none

module fspa_datapath
    import fspa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire in_item_t              s_payload,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_payload,
    input  wire fspa_cmd_t             cmd,
    output fspa_sts_t                  sts
);

    localparam int TOP_W  = $clog2(POOL_DEPTH + 1);
    localparam int ADDR_W = $clog2(POOL_DEPTH);
    localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'((POOL_DEPTH < 1024) ? POOL_DEPTH : 1024);
    localparam logic [TOP_W-1:0] TOP_FULL  = TOP_W'(POOL_DEPTH);

    logic [SIZE_W-1:0] slot_bytes_reg;
    logic [CNT_W-1:0]  slot_limit_reg;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [1:0]        op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  grant_reg, grant_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  free_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic              m_valid_reg;
    out_item_t         out_reg;

    logic [CNT_W-1:0]  lim;
    logic [SIZE_W-1:0] size_eff;
    logic [TOP_W-1:0]  top_dec;
    logic              in_range;
    logic              do_pop, do_push;
    logic [31:0]       top_wide;
    logic [IDX_W+SIZE_W-1:0] product;
    logic [IDX_W-1:0]  rd_data;

    assign lim      = (slot_limit_reg < LIMIT_CAP) ? slot_limit_reg : LIMIT_CAP;
    assign size_eff = (slot_bytes_reg > SIZE_CAP) ? SIZE_CAP : slot_bytes_reg;
    assign top_dec  = top_reg - TOP_W'(1);
    assign in_range = {1'b0, idx_reg} < lim;

    always_comb begin
        top_next    = top_reg;
        hw_next     = hw_reg;
        grant_next  = '0;
        status_next = ST_OK;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        case (op_reg)
            OP_REQUEST: begin
                if (top_reg != '0) begin
                    do_pop   = 1'b1;
                    top_next = top_dec;
                end else if (hw_reg >= lim) begin
                    status_next = ST_EXHAUSTED;
                end else begin
                    grant_next = hw_reg[IDX_W-1:0];
                    hw_next    = hw_reg + CNT_W'(1);
                end
            end
            OP_RETURN: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else if (top_reg == TOP_FULL) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    do_push    = 1'b1;
                    top_next   = top_reg + TOP_W'(1);
                    grant_next = idx_reg;
                end
            end
            default: begin
                if (!in_range) begin
                    status_next = ST_RANGE;
                end else begin
                    grant_next = idx_reg;
                end
            end
        endcase
    end

    assign top_wide = 32'(top_next);
    assign product  = {{SIZE_W{1'b0}}, grant_reg} * {{IDX_W{1'b0}}, size_eff};

    fspa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_free_stack (
        .aclk    (aclk),
        .wr_en   (cmd.decide && do_push),
        .wr_addr (top_reg[ADDR_W-1:0]),
        .wr_data (idx_reg),
        .rd_en   (cmd.decide && do_pop),
        .rd_addr (top_dec[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // config writes take effect at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_bytes_reg <= 13'd16;
            slot_limit_reg <= 11'd1024;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SLOT_BYTES: slot_bytes_reg <= cfg_data;
                CFG_SLOT_LIMIT: slot_limit_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.decide) begin
                top_reg <= top_next;
                hw_reg  <= hw_next;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_payload.operation;
            idx_reg <= s_payload.slot_index;
        end
        if (cmd.decide) begin
            grant_reg  <= grant_next;
            status_reg <= status_next;
            free_reg   <= top_wide[CNT_W-1:0];
        end
        if (cmd.fetch) begin
            grant_reg <= rd_data;
        end
        if (cmd.mult) begin
            offset_reg <= product[OFS_W-1:0];
        end
        if (cmd.emit) begin
            out_reg.granted_index <= grant_reg;
            out_reg.byte_offset   <= offset_reg;
            out_reg.status        <= status_reg;
            out_reg.free_entries  <= free_reg;
        end
    end

    assign sts.pop_sel  = do_pop;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_payload    = out_reg;

endmodule

`default_nettype wire

// ----- src/fixed_slot_pool_allocator_unit.sv -----
// Top level of the fixed slot pool allocator: sequencer plus datapath.
// Depends on fspa_pkg, fspa_ctrl, fspa_datapath, fspa_ram and the assert header.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      in_item_t  (operation, slot_index)
//   m_        out        m_valid / m_ready      out_item_t (index, offset, status, free)
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The accepting edge latches the transaction; then come decide (stack pointer
// update and free stack access), fetch (pops only), multiply and emit, so
// m_valid rises when emit loads the result; only a pop passes through fetch.
// The registered free stack RAM read and the offset multiply set these steps;
// s_ready returns the cycle after emit, so one transaction runs at a time.
// A new transaction is taken from then on, even while the loaded result still
// waits on m_ready; a stalled m_ready holds the emit step.
// Reset is synchronous, active low; the free stack needs no clearing pass.
`default_nettype none

`include "fixed_slot_pool_allocator_unit_assert.svh"

module fixed_slot_pool_allocator_unit
    import fspa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_payload,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    fspa_cmd_t cmd;
    fspa_sts_t sts;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    fspa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    fspa_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one transaction in flight: ready drops right after acceptance
    `FSPA_ASSERT_NEXT(a_single_flight, s_valid && s_ready, !s_ready, "ready held after accept")

    // error results carry a zero index and offset
    `FSPA_ASSERT(a_error_zero,
        (m_valid && m_payload.status != ST_OK) |->
            (m_payload.granted_index == '0 && m_payload.byte_offset == '0),
        "error result not zeroed")

    // a result is loaded only while the sequencer is away from idle
    `FSPA_ASSERT(a_emit_busy, cmd.emit |-> !s_ready, "emit while idle")

endmodule

`default_nettype wire

// ----- dv/tb_fixed_slot_pool_allocator_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fixed slot pool allocator: random and directed
// request / return / get traffic checked against an in-bench model of the pool.
// Depends on fspa_pkg and the fixed_slot_pool_allocator_unit RTL only.

module tb_fixed_slot_pool_allocator_unit
    import fspa_pkg::*;
();

    // Usable pool size: the RTL depth, never more than a 10-bit index can name.
    localparam int unsigned POOL_SLOTS =
        (POOL_DEPTH_DEF < (1 << IDX_W)) ? POOL_DEPTH_DEF : (1 << IDX_W);
    // The decoder treats the spare operation code as a get.
    localparam logic [1:0] OP_GET_ALT = 2'd3;

    typedef struct {
        in_item_t    item;
        int unsigned lead;  // idle cycles before the transaction is offered
    } pool_cmd_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_payload;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // ------------------------------------------------------- pool model state
    // Mirrors the allocator: LIFO of returned indices, a high-water mark of
    // indices ever handed out, and the two registers as last written.
    logic [IDX_W-1:0]  free_list [POOL_SLOTS];
    int unsigned       free_cnt    = 0;
    int unsigned       water_mark  = 0;
    logic [SIZE_W-1:0] slot_size_q = 13'd16;
    logic [CNT_W-1:0]  slot_cap_q  = 11'd1024;

    // ---------------------------------------------------- stimulus bookkeeping
    pool_cmd_t   pending_ops[$];
    out_item_t   expected_results[$];
    out_item_t   head_result;
    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatches   = 0;
    int unsigned tx_idle      = 0;
    int unsigned rx_wait      = 0;
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;

    always #5 aclk = ~aclk;

    fixed_slot_pool_allocator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Indices at or above this are out of range. A limit of zero blocks
    // every fresh grant, return and get; recycled entries still pop.
    function automatic int unsigned usable_slots();
        return (slot_cap_q > POOL_SLOTS) ? POOL_SLOTS : slot_cap_q;
    endfunction

    // Applies one transaction to the model pool and returns the result the
    // allocator must produce for it.
    function automatic out_item_t pool_predict(input in_item_t cmd);
        out_item_t        res;
        int unsigned      lim;
        int unsigned      size;
        logic [31:0]      prod;
        logic             ok;
        logic [IDX_W-1:0] idx;
        lim        = usable_slots();
        ok         = 1'b1;
        idx        = cmd.slot_index;
        res        = '0;
        res.status = ST_OK;
        case (cmd.operation)
            OP_REQUEST: begin
                // Recycled slots go first, most recent return on top. Entries
                // above a lowered limit still pop.
                if (free_cnt > 0 && free_cnt <= POOL_SLOTS) begin
                    free_cnt--;
                    idx = free_list[free_cnt[IDX_W-1:0]];
                end else if (water_mark >= lim) begin
                    ok         = 1'b0;
                    res.status = ST_EXHAUSTED;
                end else begin
                    idx = IDX_W'(water_mark);
                    water_mark++;
                end
            end
            OP_RETURN: begin
                // Range check wins over overflow; duplicates and never-issued
                // indices are pushed as is.
                if (cmd.slot_index >= lim) begin
                    ok         = 1'b0;
                    res.status = ST_RANGE;
                end else if (free_cnt >= POOL_SLOTS) begin
                    ok         = 1'b0;
                    res.status = ST_OVERFLOW;
                end else begin
                    free_list[free_cnt[IDX_W-1:0]] = cmd.slot_index;
                    free_cnt++;
                end
            end
            default: begin
                // get, and the spare code decoded the same way
                if (cmd.slot_index >= lim) begin
                    ok         = 1'b0;
                    res.status = ST_RANGE;
                end
            end
        endcase
        if (ok) begin
            // slot size saturates at 4 KiB; zero size gives zero offset
            size              = 32'((slot_size_q > SIZE_CAP) ? SIZE_CAP : slot_size_q);
            prod              = idx * size;
            res.granted_index = idx;
            res.byte_offset   = prod[OFS_W-1:0];
        end
        res.free_entries = CNT_W'(free_cnt);
        return res;
    endfunction

    // ------------------------------------------------------------------ driver
    // Offers queued transactions in order; each one waits out its own lead
    // time once the channel is free. Prediction happens at acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_idle = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(pool_predict(s_payload));
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (tx_idle < pending_ops[0].lead) begin
                    tx_idle++;
                    s_valid <= 1'b0;
                end else begin
                    s_payload <= pending_ops[0].item;
                    s_valid   <= 1'b1;
                    tx_idle = 0;
                    void'(pending_ops.pop_front());
                end
            end
        end
    end

    // ----------------------------------------------------------------- monitor
    // Checks every result transaction against the oldest prediction, then
    // holds m_ready low for a random stall. Calm stretches keep it high.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: index %0d offset %0d status %0d free %0d",
                           m_payload.granted_index, m_payload.byte_offset,
                           m_payload.status, m_payload.free_entries);
                    mismatches++;
                end else begin
                    head_result = expected_results.pop_front();
                    if (m_payload.granted_index !== head_result.granted_index) begin
                        $error("granted_index: expected %0d, actual %0d",
                               head_result.granted_index, m_payload.granted_index);
                        mismatches++;
                    end
                    if (m_payload.byte_offset !== head_result.byte_offset) begin
                        $error("byte_offset: expected %0d, actual %0d",
                               head_result.byte_offset, m_payload.byte_offset);
                        mismatches++;
                    end
                    if (m_payload.status !== head_result.status) begin
                        $error("status: expected %0d, actual %0d",
                               head_result.status, m_payload.status);
                        mismatches++;
                    end
                    if (m_payload.free_entries !== head_result.free_entries) begin
                        $error("free_entries: expected %0d, actual %0d",
                               head_result.free_entries, m_payload.free_entries);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------- stimulus helpers
    task automatic queue_op(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        pool_cmd_t cmd;
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        cmd.item.operation  = op;
        cmd.item.slot_index = idx;
        cmd.lead            = tx_calm ? 0 : $urandom_range(0, 13);
        pending_ops.push_back(cmd);
        queued_cnt++;
    endtask

    // Waits until every queued transaction is accepted and answered, then lets
    // the clock run on so the pipeline is empty before a register write.
    task automatic drain_pool();
        while (accepted_cnt != queued_cnt || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_sel,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= reg_sel;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (reg_sel == CFG_SLOT_BYTES) slot_size_q = value;
        else slot_cap_q = value[CNT_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mixed traffic with a per-phase request share: the stack grows in some
    // phases and drains toward exhaustion in others. Most returns and gets
    // are in range; the rest use any index. Request indices are don't-care.
    task automatic queue_mixed_phase(input int unsigned count);
        int unsigned      lim;
        int unsigned      req_pct;
        int unsigned      roll;
        logic [IDX_W-1:0] idx;
        lim     = usable_slots();
        req_pct = $urandom_range(25, 65);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (lim > 0 && $urandom_range(0, 6) != 0) idx = IDX_W'($urandom_range(0, lim - 1));
            else idx = IDX_W'($urandom());
            if (roll < req_pct) queue_op(OP_REQUEST, IDX_W'($urandom()));
            else if (roll < 92) queue_op(OP_RETURN, idx);
            else if (roll < 97) queue_op(OP_GET, idx);
            else queue_op(OP_GET_ALT, idx);
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        int unsigned       phase;
        int unsigned       fill;
        logic [SIZE_W-1:0] size_val;
        logic [CFG_DATA_W-1:0] cap_val;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: 16-byte slots, full pool. Fresh grants come from
        // the high-water mark, then both ends of the index range are queried.
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_REQUEST, 10'd1023);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_GET, 10'd0);
        queue_op(OP_GET, 10'd1023);
        queue_op(OP_GET_ALT, 10'd1023);
        // duplicate return, then a return of an index never handed out
        queue_op(OP_RETURN, 10'd1);
        queue_op(OP_RETURN, 10'd1);
        queue_op(OP_RETURN, 10'd1000);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_RETURN, 10'd3);
        drain_pool();

        // Oversized slot (caps at 4096) and a limit of two with index 3 and
        // index 1 still on the stack: both must pop despite the lower limit.
        write_reg(CFG_SLOT_BYTES, 13'h1FFF);
        write_reg(CFG_SLOT_LIMIT, 13'd2);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_GET, 10'd1);
        queue_op(OP_GET, 10'd2);
        queue_op(OP_RETURN, 10'd1023);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_RETURN, 10'd0);
        queue_op(OP_REQUEST, 10'd0);
        drain_pool();

        // Zero slot size and a zero limit (upper data bits set, ignored).
        write_reg(CFG_SLOT_BYTES, 13'd0);
        write_reg(CFG_SLOT_LIMIT, 13'h1800);
        queue_op(OP_REQUEST, 10'd0);
        queue_op(OP_RETURN, 10'd0);
        queue_op(OP_GET, 10'd0);
        drain_pool();
        write_reg(CFG_SLOT_LIMIT, 13'h1FFF);
        queue_op(OP_GET, 10'd1023);
        queue_op(OP_RETURN, 10'h2AA);
        drain_pool();

        // Random phases, first ones at the register extremes.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin size_val = 13'd1;    cap_val = 13'd1;    end
                1: begin size_val = 13'd4096; cap_val = 13'd1024; end
                2: begin size_val = 13'h1FFF; cap_val = 13'h1FFF; end
                3: begin size_val = SIZE_W'($urandom_range(1, 4096)); cap_val = 13'd2; end
                default: begin
                    size_val = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom())
                                                           : SIZE_W'($urandom_range(1, 4096));
                    case ($urandom_range(0, 3))
                        0:       cap_val = CFG_DATA_W'($urandom_range(1, 16));
                        1:       cap_val = CFG_DATA_W'($urandom_range(17, 1024));
                        2:       cap_val = CFG_DATA_W'($urandom());
                        default: cap_val = CFG_DATA_W'($urandom_range(1, 64));
                    endcase
                end
            endcase
            write_reg(CFG_SLOT_BYTES, size_val);
            write_reg(CFG_SLOT_LIMIT, cap_val);
            queue_mixed_phase($urandom_range(6, 14));
            drain_pool();

            if (phase == 5) begin
                // Push until the free stack is full and a few returns past
                // it overflow; then pop and push around the full mark.
                write_reg(CFG_SLOT_LIMIT, 13'd1024);
                fill = POOL_SLOTS - free_cnt + 4;
                repeat (fill) queue_op(OP_RETURN, IDX_W'($urandom()));
                repeat (3) queue_op(OP_REQUEST, IDX_W'($urandom()));
                repeat (3) queue_op(OP_RETURN, IDX_W'($urandom()));
                drain_pool();
            end
        end

        repeat (12) @(posedge aclk);
        if (mismatches == 0) begin
            $display("fixed_slot_pool_allocator_unit regression: pass");
        end else begin
            $display("fixed_slot_pool_allocator_unit regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #5_000_000;
        $display("fixed_slot_pool_allocator_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/fspa_pkg.sv
src/fspa_ram.sv
src/fspa_ctrl.sv
src/fspa_datapath.sv
src/fixed_slot_pool_allocator_unit.sv
dv/tb_fixed_slot_pool_allocator_unit.sv
